// ===== design/i2csrm_pkg.sv =====
package i2csrm_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_START_WR = 2'd0;
  localparam logic [1:0] REQ_WR_BYTE  = 2'd1;
  localparam logic [1:0] REQ_START_RD = 2'd2;
  localparam logic [1:0] REQ_RD_BYTE  = 2'd3;

  localparam logic [7:0] PAST_END_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] wdata;
  } in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       stored;
    logic [7:0] base_addr;
  } out_t;

  // memory access issued by the control logic for one item
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } mem_req_t;

  // per-item result flags carried into the output register
  typedef struct packed {
    logic       stored;
    logic       rd_mem;
    logic       rd_ff;
    logic [7:0] base_addr;
  } res_t;

endpackage

// ===== design/i2csrm_mem.sv =====
module i2csrm_mem #(
  parameter int MEM_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2csrm_pkg::mem_req_t req_i,
  output logic [7:0]           rdata_o
);
  import i2csrm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]           mem_q [MEM_BYTES];
  logic [MEM_BYTES-1:0] vld_q;
  logic [7:0]           rd_q;
  logic                 rd_vld_q;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  assign waddr = req_i.waddr[AW-1:0];
  assign raddr = req_i.raddr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // entry valid bits stand in for the cleared contents after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : 8'h00;

  a_no_rw_same_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.we && req_i.re))
    else $error("read and write issued for one item");

endmodule

// ===== design/i2csrm_ctrl.sv =====
module i2csrm_ctrl #(
  parameter int MEM_BYTES     = 64,
  parameter int GENERAL_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  i2csrm_pkg::in_t      item_i,
  input  logic                 service_mode_i,
  output i2csrm_pkg::mem_req_t mem_req_o,
  output i2csrm_pkg::res_t     res_o
);
  import i2csrm_pkg::*;

  localparam int RPW = $clog2(MEM_BYTES + 1);
  localparam int GEN_CLAMP = (GENERAL_BYTES > MEM_BYTES) ? MEM_BYTES : GENERAL_BYTES;
  localparam logic [8:0]     MEM_LIM = 9'(MEM_BYTES);
  localparam logic [8:0]     GEN_LIM = 9'(GEN_CLAMP);
  localparam logic [RPW-1:0] RP_END  = RPW'(MEM_BYTES);

  // write phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ADDR  = 2'd1;
  localparam logic [1:0] PH_STORE = 2'd2;
  localparam logic [1:0] PH_DROP  = 2'd3;

  logic [1:0]     phase_q, phase_d;
  logic [7:0]     base_q, base_d;
  logic [7:0]     wptr_q, wptr_d;
  logic [RPW-1:0] rptr_q, rptr_d;
  logic [8:0]     limit;

  assign limit = service_mode_i ? MEM_LIM : GEN_LIM;

  always_comb begin
    phase_d   = phase_q;
    base_d    = base_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    mem_req_o = '0;
    res_o     = '0;
    unique case (item_i.req_type)
      REQ_START_WR: begin
        phase_d = PH_ADDR;
      end
      REQ_WR_BYTE: begin
        if (phase_q == PH_ADDR) begin
          base_d = item_i.wdata;
          if ({1'b0, item_i.wdata} < limit) begin
            wptr_d  = item_i.wdata;
            phase_d = PH_STORE;
          end else begin
            phase_d = PH_DROP;
          end
        end else if (phase_q == PH_STORE) begin
          if ({1'b0, wptr_q} < limit && {1'b0, wptr_q} < MEM_LIM) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = wptr_q;
            mem_req_o.wdata = item_i.wdata;
            res_o.stored    = 1'b1;
            if ({1'b0, wptr_q} + 9'd1 >= limit) begin
              phase_d = PH_DROP;
            end else begin
              wptr_d = wptr_q + 8'd1;
            end
          end else begin
            phase_d = PH_DROP;
          end
        end
      end
      REQ_START_RD: begin
        // a base at or past the end parks the pointer at exhausted
        rptr_d  = ({1'b0, base_q} < MEM_LIM) ? RPW'(base_q) : RP_END;
        phase_d = PH_IDLE;
      end
      REQ_RD_BYTE: begin
        if (rptr_q < RP_END) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = 8'(rptr_q);
          res_o.rd_mem    = 1'b1;
          rptr_d          = rptr_q + RPW'(1);
        end else begin
          res_o.rd_ff = 1'b1;
          rptr_d      = RP_END;
        end
      end
      default: begin
      end
    endcase
    res_o.base_addr = base_d;
    if (!advance_i) begin
      mem_req_o.we = 1'b0;
      mem_req_o.re = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      base_q  <= 8'h00;
      wptr_q  <= 8'h00;
      rptr_q  <= RP_END;
    end else if (advance_i) begin
      phase_q <= phase_d;
      base_q  <= base_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
    end
  end

  a_store_moves_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |=> (wptr_q == $past(wptr_q) + 8'd1) || (phase_q == PH_DROP))
    else $error("store neither advanced the pointer nor ended the write");

  a_rptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> rptr_q <= RP_END)
    else $error("read pointer beyond memory end");

endmodule

// ===== design/i2c_slave_register_memory_unit.sv =====
// byte register memory behind an i2c slave front end
//
// input channel (in_valid_i / in_stall_o / in_data_i) carries one bus event
// per beat: start write, write byte, start read or read byte. every beat
// yields exactly one result beat on the output channel (out_valid_o /
// out_stall_i / out_data_o) with the read byte, the stored flag and the
// base address pointer as it stands after the event.
// each beat passes through the input register and then the result
// register, where the registered memory read port delivers its byte.
// throughput is one beat per cycle while the receiver does not stall; the
// single memory port and the pointer registers are updated once per event.
// when the receiver stalls, the result register holds, the item in the input
// register waits, and in_stall_o rises once that register is occupied.
// reset clears base and write pointers, parks the read pointer at exhausted
// and clears the entry valid bits, so memory reads as zero at once with no
// clearing pass. service mode resets to zero; the user writes it through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce this.
module i2c_slave_register_memory_unit #(
  parameter int MEM_BYTES     = 64,
  parameter int GENERAL_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2csrm_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2csrm_pkg::out_t  out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import i2csrm_pkg::*;

  logic     a_valid_q;
  in_t      a_item_q;
  logic     b_valid_q;
  res_t     b_res_q;
  logic     svc_q;
  logic     advance;
  logic     in_take;
  mem_req_t mem_req;
  res_t     res;
  logic [7:0] mem_rdata;

  // the held item moves on when the result register is free or drains now
  assign advance    = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o = a_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // service mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svc_q <= 1'b0;
    end else if (cfg_we_i) begin
      svc_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (advance) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_item_q <= in_data_i;
    end
  end

  i2csrm_ctrl #(
    .MEM_BYTES     (MEM_BYTES),
    .GENERAL_BYTES (GENERAL_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .item_i         (a_item_q),
    .service_mode_i (svc_q),
    .mem_req_o      (mem_req),
    .res_o          (res)
  );

  // read byte lands in the memory's output register alongside the result
  i2csrm_mem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_res_q <= res;
    end
  end

  assign out_valid_o          = b_valid_q;
  assign out_data_o.rdata     = b_res_q.rd_mem ? mem_rdata :
                                (b_res_q.rd_ff ? PAST_END_BYTE : 8'h00);
  assign out_data_o.stored    = b_res_q.stored;
  assign out_data_o.base_addr = b_res_q.base_addr;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> b_valid_q)
    else $error("result lost after advance");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !advance) |=> a_valid_q && $stable(a_item_q))
    else $error("waiting item overwritten");

endmodule

// ===== tb/regmem_checker.sv =====
`timescale 1ns / 100ps

module regmem_checker #(
  parameter int MEM_BYTES     = 64,
  parameter int GENERAL_BYTES = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  i2csrm_pkg::in_t  in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  i2csrm_pkg::out_t out_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output int               err_count_o,
  output int               pending_o
);
  import i2csrm_pkg::*;

  typedef enum logic [1:0] {
    WR_IDLE,
    WR_ADDR,
    WR_STORE,
    WR_DROP
  } wr_phase_e;

  // shadow of the register memory and its pointers
  logic [7:0] mem_img [MEM_BYTES];
  logic [7:0] base_ptr;
  logic [7:0] wr_ptr;
  int         rd_ptr;
  wr_phase_e  wr_phase;
  logic       svc_mode;

  out_t pending_results [$];
  out_t next_res;
  out_t oldest_res;

  task automatic apply_bus_event(input in_t ev, output out_t res);
    int lim;
    lim = svc_mode ? MEM_BYTES : ((GENERAL_BYTES > MEM_BYTES) ? MEM_BYTES : GENERAL_BYTES);
    res = '0;
    case (ev.req_type)
      REQ_START_WR: wr_phase = WR_ADDR;
      REQ_WR_BYTE: begin
        if (wr_phase == WR_ADDR) begin
          base_ptr = ev.wdata;
          if (int'(ev.wdata) < lim) begin
            wr_ptr   = ev.wdata;
            wr_phase = WR_STORE;
          end else begin
            wr_phase = WR_DROP;
          end
        end else if (wr_phase == WR_STORE) begin
          // limit is taken from the mode in force now
          if (int'(wr_ptr) < lim && int'(wr_ptr) < MEM_BYTES) begin
            mem_img[wr_ptr] = ev.wdata;
            res.stored      = 1'b1;
            if (int'(wr_ptr) + 1 >= lim) wr_phase = WR_DROP;
            else wr_ptr = wr_ptr + 8'd1;
          end else begin
            wr_phase = WR_DROP;
          end
        end
      end
      REQ_START_RD: begin
        rd_ptr   = int'(base_ptr);
        wr_phase = WR_IDLE;
      end
      REQ_RD_BYTE: begin
        if (rd_ptr < MEM_BYTES) begin
          res.rdata = mem_img[rd_ptr];
          rd_ptr    = rd_ptr + 1;
        end else begin
          res.rdata = PAST_END_BYTE;
          rd_ptr    = MEM_BYTES;
        end
      end
      default: ;
    endcase
    res.base_addr = base_ptr;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_BYTES; i++) mem_img[i] = 8'h00;
      base_ptr    = 8'h00;
      wr_ptr      = 8'h00;
      rd_ptr      = MEM_BYTES;
      wr_phase    = WR_IDLE;
      svc_mode    = 1'b0;
      err_count_o = 0;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) svc_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        apply_bus_event(in_data_i, next_res);
        pending_results.push_back(next_res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing pending, expected none, actual %h",
                   $time, out_data_i);
          err_count_o++;
        end else begin
          oldest_res = pending_results.pop_front();
          check_field("rdata", oldest_res.rdata, out_data_i.rdata);
          check_field("stored", {7'd0, oldest_res.stored}, {7'd0, out_data_i.stored});
          check_field("base_addr", oldest_res.base_addr, out_data_i.base_addr);
        end
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import i2csrm_pkg::*;

  localparam int MEM_BYTES      = 64;
  localparam int GENERAL_BYTES  = 32;
  // generous bound on cycles without any beat moving on either channel
  localparam int WATCHDOG_LIMIT = 500;
  // drain margin after the pipeline empties, before a mode write
  localparam int DRAIN_CYCLES   = 4;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_EVENTS   = 119;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  out_t out_data_o;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  int err_count;
  int pending;
  int quiet_cycles = 0;
  // when set, neither side inserts idle cycles
  bit calm_phase   = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  i2c_slave_register_memory_unit #(
    .MEM_BYTES    (MEM_BYTES),
    .GENERAL_BYTES(GENERAL_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  regmem_checker #(
    .MEM_BYTES    (MEM_BYTES),
    .GENERAL_BYTES(GENERAL_BYTES)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_i (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  // one bus event beat; called and returns at a falling edge
  task automatic put_event(input logic [1:0] req, input logic [7:0] data);
    int  gap;
    in_t ev;
    gap         = calm_phase ? 0 : $urandom_range(0, 5);
    ev.req_type = req;
    ev.wdata    = data;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mode is written only with the pipeline empty
  task automatic program_mode(input logic mode);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed transactions with random content, some noise
  task automatic run_random_phase(input int budget);
    int left;
    int kind;
    int n;
    logic [7:0] addr;
    left = budget;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      n    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
      // keep the phase close to its budget
      if (n > left) n = left;
      if (kind < 45) begin
        // write transaction: start, address beat, data beats
        addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, MEM_BYTES + 4));
        put_event(REQ_START_WR, 8'($urandom));
        put_event(REQ_WR_BYTE, addr);
        repeat (n) put_event(REQ_WR_BYTE, 8'($urandom));
        left = left - 2 - n;
      end else if (kind < 85) begin
        // read transaction from the current base address
        put_event(REQ_START_RD, 8'($urandom));
        repeat (n) put_event(REQ_RD_BYTE, 8'($urandom));
        left = left - 1 - n;
      end else begin
        // stray beat of random type, which may break the transaction that is open
        put_event(2'($urandom), 8'($urandom));
        left--;
      end
    end
  endtask

  // receiver: random stall before each result beat
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm_phase ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // watchdog on beats moving through either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // read byte before any start read, write byte while idle
    put_event(REQ_RD_BYTE, 8'h00);
    put_event(REQ_WR_BYTE, 8'hFF);
    // write near the general limit; the second data beat reaches it, the third is dropped
    put_event(REQ_START_WR, 8'hFF);
    put_event(REQ_WR_BYTE, 8'h1E);
    put_event(REQ_WR_BYTE, 8'h00);
    put_event(REQ_WR_BYTE, 8'hFF);
    put_event(REQ_WR_BYTE, 8'hA5);
    // out-of-range base address, all beats dropped, read past end at once
    put_event(REQ_START_WR, 8'h00);
    put_event(REQ_WR_BYTE, 8'hFF);
    put_event(REQ_WR_BYTE, 8'h55);
    put_event(REQ_START_RD, 8'h00);
    put_event(REQ_RD_BYTE, 8'hFF);
    // reopened write, then start read ends it, then a dropped write beat
    put_event(REQ_START_WR, 8'h00);
    put_event(REQ_START_WR, 8'h00);
    put_event(REQ_WR_BYTE, 8'h1F);
    put_event(REQ_START_RD, 8'hFF);
    put_event(REQ_RD_BYTE, 8'h00);
    put_event(REQ_RD_BYTE, 8'h00);
    put_event(REQ_WR_BYTE, 8'h77);

    // service region write, then the mode drops within the transaction
    program_mode(1'b1);
    put_event(REQ_START_WR, 8'h00);
    put_event(REQ_WR_BYTE, 8'h3E);
    put_event(REQ_WR_BYTE, 8'hC3);
    program_mode(1'b0);
    put_event(REQ_WR_BYTE, 8'h99);

    // top of memory in service mode, then read across the end
    program_mode(1'b1);
    put_event(REQ_START_WR, 8'h00);
    put_event(REQ_WR_BYTE, 8'h3F);
    put_event(REQ_WR_BYTE, 8'h81);
    put_event(REQ_WR_BYTE, 8'h18);
    put_event(REQ_START_RD, 8'h00);
    put_event(REQ_RD_BYTE, 8'h00);
    put_event(REQ_RD_BYTE, 8'h00);

    // random phases, each with its own mode; two run without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_mode((p < 4) ? p[0] : 1'($urandom));
      calm_phase = (p == 2) || (p == 5);
      run_random_phase(PHASE_EVENTS);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
